FILE: hdl/sce_pkg.sv
// Shared types, byte codes and pattern constants for the CREATE TABLE extractor.
`default_nettype none

package sce_pkg;

	localparam int NAME_MAX_DEF     = 40;
	localparam int WINDOW_DEPTH_DEF = 57;

	localparam int NAME_WORDS = 5;
	localparam int NAME_BYTES = 40;
	localparam int WORD_W     = 64;
	localparam int LEN_W      = 6;
	localparam int CFG_IDX_W  = 3;

	localparam int PREFIX_LEN = 14;
	localparam int SUFFIX_LEN = 3;
	// wide enough for pattern length, fill count and cell offsets
	localparam int MATCH_W    = 7;

	typedef logic [7:0] byte_t;

	localparam byte_t PREFIX_BYTES [PREFIX_LEN] = '{
		8'h43, 8'h52, 8'h45, 8'h41, 8'h54, 8'h45, 8'h20,
		8'h54, 8'h41, 8'h42, 8'h4C, 8'h45, 8'h20, 8'h60
	};
	localparam byte_t SUFFIX_BYTES [SUFFIX_LEN] = '{8'h60, 8'h20, 8'h28};

	localparam byte_t CHAR_QUOTE = 8'h27;
	localparam byte_t CHAR_NL    = 8'h0A;
	localparam byte_t CHAR_SEMI  = 8'h3B;
	localparam byte_t CHAR_SLASH = 8'h2F;
	localparam byte_t CHAR_STAR  = 8'h2A;
	localparam byte_t CHAR_DASH  = 8'h2D;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NAME_WORD_0 = 3'd0,
		REG_NAME_WORD_1 = 3'd1,
		REG_NAME_WORD_2 = 3'd2,
		REG_NAME_WORD_3 = 3'd3,
		REG_NAME_WORD_4 = 3'd4,
		REG_NAME_LENGTH = 3'd5
	} cfg_reg_t;

	// broadcast to every window cell
	typedef struct packed {
		logic             step;
		byte_t            in_byte;
		logic [LEN_W-1:0] eff_len;
	} cell_ctl_t;

	typedef struct packed {
		byte_t data;
		logic  last;
	} res_t;

endpackage

`default_nettype wire

FILE: hdl/sce_cell.sv
// One window cell: holds a byte, shifts toward the head, compares against its pattern byte.
`default_nettype none

module sce_cell #(
	parameter int IDX = 0
) (
	input  wire logic               clk,
	input  wire sce_pkg::cell_ctl_t ctl,
	input  wire logic               load,
	input  wire sce_pkg::byte_t     next_byte,
	input  wire sce_pkg::byte_t     fixed_byte,
	output sce_pkg::byte_t          cur_byte,
	output logic                    hit
);

	localparam int K  = IDX - sce_pkg::PREFIX_LEN;
	localparam int MW = sce_pkg::MATCH_W;

	sce_pkg::byte_t byte_q;
	sce_pkg::byte_t pat;
	logic           active;

	// advance from the neighbor on a pop; take the new byte when this is the write slot
	always_ff @(posedge clk) begin
		if (ctl.step) begin
			byte_q <= load ? ctl.in_byte : next_byte;
		end else if (load) begin
			byte_q <= ctl.in_byte;
		end
	end

	if (IDX < sce_pkg::PREFIX_LEN) begin : g_prefix
		assign pat    = fixed_byte;
		assign active = 1'b1;
	end else begin : g_tail
		logic [MW-1:0] rel;
		assign rel = MW'(K) - MW'(ctl.eff_len);
		always_comb begin
			if (MW'(K) < MW'(ctl.eff_len)) begin
				pat    = fixed_byte;
				active = 1'b1;
			end else if (rel < MW'(sce_pkg::SUFFIX_LEN)) begin
				pat    = sce_pkg::SUFFIX_BYTES[rel[1:0]];
				active = 1'b1;
			end else begin
				pat    = fixed_byte;
				active = 1'b0;
			end
		end
	end

	assign cur_byte = byte_q;
	assign hit      = !active || (byte_q == pat);

endmodule

`default_nettype wire

FILE: hdl/sce_outq.sv
// Two-entry result queue that decouples the window from the output handshake.
`default_nettype none

module sce_outq (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire sce_pkg::res_t push_data,
	input  wire logic          out_ready,
	output logic               valid,
	output sce_pkg::res_t      head,
	output logic               full
);

	logic [1:0]    count_q;
	sce_pkg::res_t slot0_q;
	sce_pkg::res_t slot1_q;
	logic          pop;

	assign valid = (count_q != 2'd0);
	assign full  = (count_q == 2'd2);
	assign head  = slot0_q;
	assign pop   = valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	// push never arrives while full
	always_ff @(posedge clk) begin
		if (count_q == 2'd2) begin
			if (pop) begin
				slot0_q <= slot1_q;
			end
		end else if (push) begin
			if (count_q == 2'd0 || pop) begin
				slot0_q <= push_data;
			end else begin
				slot1_q <= push_data;
			end
		end
	end

endmodule

`default_nettype wire

FILE: hdl/sql_create_table_extractor.sv
// Top level of the CREATE TABLE extractor: window cell chain, head classifier, result queue.
//
// Usage:
//   Input requests (in_valid/in_ready) carry one SQL text byte each plus is_final on
//   the last byte of a text. Output requests (out_valid/out_ready) carry emitted
//   statement bytes; last_of_run marks the last result caused by one input request.
//   Configuration (cfg_we/cfg_index/cfg_data) loads the table name words and length;
//   write it only while the block is idle. Writes to unknown indexes are dropped.
// Throughput: one byte per cycle in steady state while the output queue has room.
//   Bytes enter a chain of WINDOW_DEPTH cells; once the chain is full, each cycle pops
//   the head byte (classified against the whole window in parallel) and shifts in the next one.
// Result path: once the window is full, the head byte is classified combinationally as it
//   pops, and its result is registered into the output queue that drives out_valid.
// Final byte: after is_final the chain drains one cell per cycle while the output queue
//   has room, and in_ready stays low until the chain is empty; then the per-text state
//   returns to its reset values and the next text may start.
// Stall: a two-entry output queue holds up to two results while out_ready is low; while
//   it is full the head does not pop and a full window holds off new input.
// Reset: arst_n clears fill count, comment/quote/emit state and the queue, and sets
//   the name registers to zero with length one. Window bytes are not cleared; only
//   bytes below the fill count are ever used.
`default_nettype none

module sql_create_table_extractor #(
	parameter int NAME_MAX     = sce_pkg::NAME_MAX_DEF,
	parameter int WINDOW_DEPTH = sce_pkg::WINDOW_DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [sce_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [sce_pkg::WORD_W-1:0]    cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [7:0]                    text_byte,
	input  wire logic                          is_final,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [7:0]                         out_byte,
	output logic                               last_of_run
);

	localparam int FILL_W  = $clog2(WINDOW_DEPTH + 1);
	localparam int IDX_W   = $clog2(WINDOW_DEPTH);
	localparam int LEN_W   = sce_pkg::LEN_W;
	localparam int MW      = sce_pkg::MATCH_W;
	localparam int FIXED_L = sce_pkg::PREFIX_LEN + sce_pkg::SUFFIX_LEN;
	localparam int LEN_MAX = (NAME_MAX < WINDOW_DEPTH - FIXED_L) ? NAME_MAX
	                                                             : WINDOW_DEPTH - FIXED_L;

	// Configuration registers
	logic [sce_pkg::WORD_W-1:0] name_word_q [sce_pkg::NAME_WORDS];
	logic [LEN_W-1:0]           name_length_q;
	logic [LEN_W-1:0]           eff_len;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int w = 0; w < sce_pkg::NAME_WORDS; w++) begin
				name_word_q[w] <= '0;
			end
			name_length_q <= LEN_W'(1);
		end else if (cfg_we) begin
			unique case (sce_pkg::cfg_reg_t'(cfg_index))
				sce_pkg::REG_NAME_WORD_0: name_word_q[0] <= cfg_data;
				sce_pkg::REG_NAME_WORD_1: name_word_q[1] <= cfg_data;
				sce_pkg::REG_NAME_WORD_2: name_word_q[2] <= cfg_data;
				sce_pkg::REG_NAME_WORD_3: name_word_q[3] <= cfg_data;
				sce_pkg::REG_NAME_WORD_4: name_word_q[4] <= cfg_data;
				sce_pkg::REG_NAME_LENGTH: name_length_q  <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp the name length to what the window and the name limit allow
	always_comb begin
		if (name_length_q == '0) begin
			eff_len = LEN_W'(1);
		end else if (name_length_q > LEN_W'(LEN_MAX)) begin
			eff_len = LEN_W'(LEN_MAX);
		end else begin
			eff_len = name_length_q;
		end
	end

	// Per-text control state
	logic [FILL_W-1:0] fill_q;
	logic              drain_q;
	logic              pend_v_q;
	sce_pkg::byte_t    pend_b_q;
	logic              in_quote_q;
	logic              in_block_q;
	logic              in_line_q;
	logic              searching_q;
	logic              emitting_q;
	sce_pkg::byte_t    prev_q;

	logic              q_full;
	logic              step;
	logic              flush;
	logic              accept;
	logic [FILL_W-1:0] wpos_full;
	logic [IDX_W-1:0]  wpos;

	// while the queue is not full, a full window pops one byte per cycle and a draining window pops until empty
	assign step = !q_full && (drain_q ? (fill_q != '0) : (fill_q == FILL_W'(WINDOW_DEPTH)));
	assign flush = drain_q && (fill_q == '0) && !q_full;
	assign in_ready = !drain_q && ((fill_q != FILL_W'(WINDOW_DEPTH)) || !q_full);
	assign accept = in_valid && in_ready;
	// new byte lands behind the last held byte, after this cycle's pop
	assign wpos_full = fill_q - FILL_W'(step);
	assign wpos = wpos_full[IDX_W-1:0];

	// Cell chain
	sce_pkg::cell_ctl_t      ctl;
	sce_pkg::byte_t          cell_byte [WINDOW_DEPTH];
	logic [WINDOW_DEPTH-1:0] hit;
	logic [WINDOW_DEPTH-1:0] load;

	assign ctl.step    = step;
	assign ctl.in_byte = text_byte;
	assign ctl.eff_len = eff_len;

	always_comb begin
		for (int i = 0; i < WINDOW_DEPTH; i++) begin
			load[i] = accept && (wpos == IDX_W'(i));
		end
	end

	for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
		sce_pkg::byte_t fixed_byte;
		sce_pkg::byte_t next_byte;

		// prefix cells see a constant; name cells see their configured byte
		if (i < sce_pkg::PREFIX_LEN) begin : g_fx
			assign fixed_byte = sce_pkg::PREFIX_BYTES[i];
		end else if (i - sce_pkg::PREFIX_LEN < sce_pkg::NAME_BYTES) begin : g_fx
			assign fixed_byte =
				name_word_q[(i - sce_pkg::PREFIX_LEN) / 8][8 * ((i - sce_pkg::PREFIX_LEN) % 8) +: 8];
		end else begin : g_fx
			assign fixed_byte = '0;
		end

		if (i == WINDOW_DEPTH - 1) begin : g_nx
			assign next_byte = '0;
		end else begin : g_nx
			assign next_byte = cell_byte[i + 1];
		end

		sce_cell #(
			.IDX(i)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.load      (load[i]),
			.next_byte (next_byte),
			.fixed_byte(fixed_byte),
			.cur_byte  (cell_byte[i]),
			.hit       (hit[i])
		);
	end

	// Head classification
	sce_pkg::byte_t c0;
	sce_pkg::byte_t c1;
	logic           two_held;
	logic           match;
	logic           nx_quote;
	logic           nx_block;
	logic           nx_line;
	logic           nx_search;
	logic           nx_emit;
	logic           made;
	sce_pkg::byte_t res_byte;

	assign c0       = cell_byte[0];
	assign c1       = cell_byte[1];
	assign two_held = (fill_q >= FILL_W'(2));
	// a pattern that runs past the held bytes fails
	assign match    = (&hit) && ((MW'(eff_len) + MW'(FIXED_L)) <= MW'(fill_q));

	always_comb begin
		nx_quote  = in_quote_q;
		nx_block  = in_block_q;
		nx_line   = in_line_q;
		nx_search = searching_q;
		nx_emit   = emitting_q;
		made      = 1'b0;
		res_byte  = c0;
		if (!in_line_q && !in_block_q && !in_quote_q && c0 == sce_pkg::CHAR_QUOTE) begin
			nx_quote = 1'b1;
		end else if (!in_quote_q && !in_line_q && two_held &&
		             c0 == sce_pkg::CHAR_SLASH && c1 == sce_pkg::CHAR_STAR) begin
			nx_block = 1'b1;
		end else if (!in_quote_q && !in_block_q && two_held &&
		             c0 == sce_pkg::CHAR_DASH && c1 == sce_pkg::CHAR_DASH) begin
			nx_line = 1'b1;
		end else if (in_quote_q) begin
			if (c0 == sce_pkg::CHAR_QUOTE) begin
				nx_quote = 1'b0;
			end
		end else if (in_block_q) begin
			if (two_held && c0 == sce_pkg::CHAR_STAR && c1 == sce_pkg::CHAR_SLASH) begin
				nx_block = 1'b0;
			end
		end else if (in_line_q) begin
			if (c0 == sce_pkg::CHAR_NL) begin
				nx_line = 1'b0;
			end
		end else if (searching_q && match) begin
			nx_emit   = 1'b1;
			nx_search = 1'b0;
		end else if (emitting_q && prev_q == sce_pkg::CHAR_SEMI) begin
			// replace the byte after the terminator with a newline and stop
			made     = 1'b1;
			res_byte = sce_pkg::CHAR_NL;
			nx_emit  = 1'b0;
		end
		if (!made && nx_emit) begin
			made     = 1'b1;
			res_byte = c0;
		end
	end

	// Result routing: during drain hold one result back so the last one can be marked
	logic          push;
	sce_pkg::res_t push_res;

	always_comb begin
		push     = 1'b0;
		push_res = '{data: res_byte, last: 1'b1};
		if (step && made) begin
			if (!drain_q) begin
				push     = 1'b1;
				push_res = '{data: res_byte, last: 1'b1};
			end else if (pend_v_q) begin
				push     = 1'b1;
				push_res = '{data: pend_b_q, last: 1'b0};
			end
		end
		if (flush && pend_v_q) begin
			push     = 1'b1;
			push_res = '{data: pend_b_q, last: 1'b1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			drain_q     <= 1'b0;
			pend_v_q    <= 1'b0;
			in_quote_q  <= 1'b0;
			in_block_q  <= 1'b0;
			in_line_q   <= 1'b0;
			searching_q <= 1'b1;
			emitting_q  <= 1'b0;
			prev_q      <= sce_pkg::CHAR_NL;
		end else begin
			fill_q <= fill_q - FILL_W'(step) + FILL_W'(accept);
			if (accept && is_final) begin
				drain_q <= 1'b1;
			end
			if (step) begin
				in_quote_q  <= nx_quote;
				in_block_q  <= nx_block;
				in_line_q   <= nx_line;
				searching_q <= nx_search;
				emitting_q  <= nx_emit;
				prev_q      <= c0;
			end
			if (step && made && drain_q) begin
				pend_v_q <= 1'b1;
			end
			// end of text: return per-text state to reset
			if (flush) begin
				drain_q     <= 1'b0;
				pend_v_q    <= 1'b0;
				in_quote_q  <= 1'b0;
				in_block_q  <= 1'b0;
				in_line_q   <= 1'b0;
				searching_q <= 1'b1;
				emitting_q  <= 1'b0;
				prev_q      <= sce_pkg::CHAR_NL;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && made && drain_q) begin
			pend_b_q <= res_byte;
		end
	end

	// Output queue
	sce_pkg::res_t q_head;

	sce_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_res),
		.out_ready(out_ready),
		.valid    (out_valid),
		.head     (q_head),
		.full     (q_full)
	);

	assign out_byte    = q_head.data;
	assign last_of_run = q_head.last;

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(WINDOW_DEPTH))
		else $error("window fill count exceeds depth");

	a_pend_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		pend_v_q |-> drain_q)
		else $error("held result outside drain");

	a_context_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({in_quote_q, in_block_q, in_line_q}))
		else $error("quote and comment states overlap");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("result pushed into full queue");

	a_final_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_final) |=> (drain_q && !in_ready))
		else $error("final byte did not start drain");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/tb_sql_create_table_extractor.sv
// Self-checking testbench for the CREATE TABLE extractor: random SQL texts against a predictor.
module tb_sql_create_table_extractor;
	timeunit 1ns;
	timeprecision 1ps;

	import sce_pkg::*;

	localparam int WIN          = WINDOW_DEPTH_DEF;
	// drain of a full window plus the output queue, with margin
	localparam int DRAIN_CYCLES = WINDOW_DEPTH_DEF + 8;
	// cycles without any request moving before the run is declared hung
	localparam int QUIET_LIMIT  = 4000;
	localparam int MAX_REPORTS  = 10;

	// register indexes that the block does not decode
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

	logic                 clk;
	logic                 arst_n      = 1'b0;
	logic                 cfg_we      = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index   = '0;
	logic [WORD_W-1:0]    cfg_data    = '0;
	logic                 in_valid    = 1'b0;
	logic                 in_ready;
	logic [7:0]           text_byte   = '0;
	logic                 is_final    = 1'b0;
	logic                 out_valid;
	logic                 out_ready   = 1'b0;
	logic [7:0]           out_byte;
	logic                 last_of_run;

	sql_create_table_extractor i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.text_byte  (text_byte),
		.is_final   (is_final),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.last_of_run(last_of_run)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Predictor state: a private copy of the window, the per-text flags and
	// the table name registers.
	// ------------------------------------------------------------------
	byte_t             text_window [WIN];
	int unsigned       win_fill     = 0;
	bit                quote_open   = 1'b0;
	bit                block_open   = 1'b0;
	bit                line_open    = 1'b0;
	bit                searching    = 1'b1;
	bit                emitting     = 1'b0;
	byte_t             prev_text    = CHAR_NL;
	logic [WORD_W-1:0] name_word_s [NAME_WORDS] = '{default: '0};
	logic [LEN_W-1:0]  name_len_s   = 6'd1;

	// statement bytes still owed by the block, oldest first
	res_t              emitted_q [$];
	res_t              oldest;
	int                mismatches   = 0;

	// idling knobs, percent of cycles
	int                sender_gap   = 0;
	int                stall_pct    = 0;

	function automatic void reset_text_state();
		win_fill   = 0;
		quote_open = 1'b0;
		block_open = 1'b0;
		line_open  = 1'b0;
		searching  = 1'b1;
		emitting   = 1'b0;
		prev_text  = CHAR_NL;
	endfunction

	// Clamp the length register to at least one and to what the name limit and the window allow.
	function automatic int name_len_eff();
		int n;
		n = name_len_s;
		if (n < 1) n = 1;
		if (n > NAME_MAX_DEF) n = NAME_MAX_DEF;
		if (n > WIN - PREFIX_LEN - SUFFIX_LEN) n = WIN - PREFIX_LEN - SUFFIX_LEN;
		return n;
	endfunction

	function automatic byte_t name_byte_at(int i);
		if (i >= NAME_BYTES) return 8'h00;
		return name_word_s[i / 8][8 * (i % 8) +: 8];
	endfunction

	function automatic byte_t create_pattern_byte(int k, int len);
		if (k < PREFIX_LEN) return PREFIX_BYTES[k];
		if (k < PREFIX_LEN + len) return name_byte_at(k - PREFIX_LEN);
		k -= PREFIX_LEN + len;
		return (k < SUFFIX_LEN) ? SUFFIX_BYTES[k] : 8'h00;
	endfunction

	function automatic bit head_pair(byte_t a, byte_t b);
		return win_fill >= 2 && text_window[0] == a && text_window[1] == b;
	endfunction

	// Full pattern at the window head; fails when the text runs out first.
	function automatic bit head_is_create();
		int len;
		int total;
		int k;
		len   = name_len_eff();
		total = PREFIX_LEN + len + SUFFIX_LEN;
		if (total > win_fill || total > WIN) return 1'b0;
		for (k = 0; k < total; k++)
			if (text_window[k] != create_pattern_byte(k, len)) return 1'b0;
		return 1'b1;
	endfunction

	// Classify the head byte, pop it, and report whether it yields a statement byte.
	function automatic bit pop_head(output byte_t r);
		byte_t c;
		bit    made;
		int    i;
		made = 1'b0;
		r    = 8'h00;
		if (win_fill == 0) return 1'b0;
		c = text_window[0];
		if (!line_open && !block_open && !quote_open && c == CHAR_QUOTE) begin
			quote_open = 1'b1;
		end else if (!quote_open && !line_open && head_pair(CHAR_SLASH, CHAR_STAR)) begin
			block_open = 1'b1;
		end else if (!quote_open && !block_open && head_pair(CHAR_DASH, CHAR_DASH)) begin
			line_open = 1'b1;
		end else if (quote_open) begin
			if (c == CHAR_QUOTE) quote_open = 1'b0;
		end else if (block_open) begin
			if (head_pair(CHAR_STAR, CHAR_SLASH)) block_open = 1'b0;
		end else if (line_open) begin
			if (c == CHAR_NL) line_open = 1'b0;
		end else if (searching && head_is_create()) begin
			emitting  = 1'b1;
			searching = 1'b0;
		end else if (emitting && prev_text == CHAR_SEMI) begin
			// the byte after the semicolon closes the statement
			r        = CHAR_NL;
			made     = 1'b1;
			emitting = 1'b0;
		end
		prev_text = c;
		if (!made && emitting) begin
			r    = c;
			made = 1'b1;
		end
		for (i = 0; i + 1 < win_fill; i++)
			text_window[i] = text_window[i + 1];
		win_fill--;
		return made;
	endfunction

	// Advance the predictor by one accepted text byte and queue what it emits.
	function automatic void extract_step(byte_t b, bit fin);
		res_t  run [$];
		byte_t r;
		if (win_fill >= WIN && pop_head(r)) run.push_back('{data: r, last: 1'b0});
		text_window[win_fill] = b;
		win_fill++;
		if (!fin) begin
			if (win_fill >= WIN && run.size() == 0 && pop_head(r))
				run.push_back('{data: r, last: 1'b0});
		end else begin
			while (win_fill > 0)
				if (pop_head(r)) run.push_back('{data: r, last: 1'b0});
			reset_text_state();
		end
		if (run.size() > 0) run[$].last = 1'b1;
		foreach (run[i]) emitted_q.push_back(run[i]);
	endfunction

	// ------------------------------------------------------------------
	// Text generation: mostly well-formed SQL fragments, some raw noise.
	// ------------------------------------------------------------------
	function automatic void add_words(ref byte_t q [$], input int n);
		int v;
		repeat (n) begin
			v = $urandom_range(0, 31);
			if (v < 26) begin
				q.push_back(byte_t'(8'h61 + v));
			end else begin
				case (v)
					26: q.push_back(8'h20);
					27: q.push_back(8'h2C);
					28: q.push_back(8'h28);
					29: q.push_back(8'h29);
					30: q.push_back(CHAR_NL);
					default: q.push_back(CHAR_STAR);
				endcase
			end
		end
	endfunction

	// Append the CREATE TABLE header for the current name, less its last cut bytes.
	function automatic void add_create(ref byte_t q [$], input int cut);
		int len;
		int k;
		len = name_len_eff();
		for (k = 0; k < PREFIX_LEN + len + SUFFIX_LEN - cut; k++)
			q.push_back(create_pattern_byte(k, len));
	endfunction

	function automatic void build_text(output byte_t txt [$]);
		int target;
		int kind;
		int plen;
		int idx;
		txt    = {};
		target = $urandom_range(1, 130);
		plen   = PREFIX_LEN + name_len_eff() + SUFFIX_LEN;
		while (txt.size() < target) begin
			kind = $urandom_range(0, 99);
			if (kind < 25) begin
				// statement header, sometimes with one bit broken
				add_create(txt, 0);
				if ($urandom_range(0, 3) == 0) begin
					idx = txt.size() - 1 - $urandom_range(0, plen - 1);
					txt[idx] = txt[idx] ^ (8'h01 << $urandom_range(0, 7));
				end
				add_words(txt, $urandom_range(0, 12));
				if ($urandom_range(0, 1)) txt.push_back(CHAR_SEMI);
			end else if (kind < 40) begin
				add_words(txt, $urandom_range(1, 15));
				txt.push_back(CHAR_SEMI);
			end else if (kind < 50) begin
				txt.push_back(CHAR_QUOTE);
				add_words(txt, $urandom_range(0, 6));
				if ($urandom_range(0, 1)) add_create(txt, 0);
				txt.push_back(CHAR_QUOTE);
			end else if (kind < 58) begin
				txt.push_back(CHAR_SLASH);
				txt.push_back(CHAR_STAR);
				add_words(txt, $urandom_range(0, 6));
				if ($urandom_range(0, 1)) add_create(txt, 0);
				txt.push_back(CHAR_STAR);
				txt.push_back(CHAR_SLASH);
			end else if (kind < 66) begin
				txt.push_back(CHAR_DASH);
				txt.push_back(CHAR_DASH);
				add_words(txt, $urandom_range(0, 10));
				if ($urandom_range(0, 2) == 0) add_create(txt, 0);
				txt.push_back(CHAR_NL);
			end else if (kind < 80) begin
				repeat ($urandom_range(1, 6)) txt.push_back(byte_t'($urandom_range(0, 255)));
			end else begin
				add_words(txt, $urandom_range(1, 10));
			end
		end
		// header cut short by the end of the text
		if ($urandom_range(0, 5) == 0) add_create(txt, $urandom_range(1, SUFFIX_LEN + 2));
	endfunction

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------
	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= MAX_REPORTS) $display("%0t: %s", $realtime, what);
	endtask

	// Send one text byte; hold valid and payload until the request is taken.
	task automatic send_byte(input byte_t b, input bit fin);
		while ($urandom_range(0, 99) < sender_gap) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		text_byte <= b;
		is_final  <= fin;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		extract_step(b, fin);
	endtask

	task automatic send_text(input byte_t txt [$]);
		foreach (txt[i]) send_byte(txt[i], i == txt.size() - 1);
	endtask

	// Leave cfg_we high; the caller drops it after the last write.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			REG_NAME_WORD_0, REG_NAME_WORD_1, REG_NAME_WORD_2,
			REG_NAME_WORD_3, REG_NAME_WORD_4: name_word_s[idx] = val;
			REG_NAME_LENGTH:                  name_len_s = val[LEN_W-1:0];
			default: ;
		endcase
	endtask

	task automatic load_name(input logic [WORD_W-1:0] w0, w1, w2, w3, w4, len_val);
		write_reg(REG_NAME_WORD_0, w0);
		write_reg(REG_NAME_WORD_1, w1);
		write_reg(REG_NAME_WORD_2, w2);
		write_reg(REG_NAME_WORD_3, w3);
		write_reg(REG_NAME_WORD_4, w4);
		write_reg(REG_NAME_LENGTH, len_val);
		cfg_we <= 1'b0;
	endtask

	// Drop valid, wait for every owed byte, then let a silent drain finish.
	task automatic settle();
		in_valid <= 1'b0;
		while (emitted_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Random texts until about `items` bytes went in; some texts run without idling.
	task automatic run_texts(input int items, input int gap, input int stall);
		byte_t txt [$];
		int    sent;
		sent = 0;
		while (sent < items) begin
			build_text(txt);
			sender_gap = ($urandom_range(0, 4) == 0) ? 0 : gap;
			stall_pct  = ($urandom_range(0, 4) == 0) ? 0 : stall;
			send_text(txt);
			sent += txt.size();
		end
		settle();
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset name is one zero byte: match it, close on the byte after ';',
	// then hide a semicolon inside a quote.
	task automatic test_directed_match();
		byte_t txt [$];
		sender_gap = 0;
		stall_pct  = 0;
		txt = {};
		add_create(txt, 0);
		txt.push_back(CHAR_SEMI);
		txt.push_back(8'hFF);
		send_text(txt);
		send_text('{CHAR_QUOTE, CHAR_SEMI, CHAR_QUOTE});
		settle();
	endtask

	// Length zero clamps to one; back-to-back traffic on both sides.
	task automatic test_no_idling();
		load_name({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
			{$urandom, $urandom}, {$urandom, $urandom}, 64'd0);
		run_texts(125, 0, 0);
	endtask

	// Longest name: the header fills the whole window.
	task automatic test_sender_gaps();
		load_name({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
			{$urandom, $urandom}, {$urandom, $urandom}, 64'd40);
		run_texts(125, 72, 0);
	endtask

	// All-ones name and length; length clamps to the maximum.
	task automatic test_receiver_stalls();
		load_name('1, '1, '1, '1, '1, '1);
		run_texts(125, 0, 72);
	endtask

	// Writes to undecoded indexes must not disturb the name.
	task automatic test_both_idle();
		write_reg(REG_SPARE_6, {$urandom, $urandom});
		write_reg(REG_SPARE_7, {$urandom, $urandom});
		load_name({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
			{$urandom, $urandom}, {$urandom, $urandom}, 64'($urandom_range(1, 40)));
		run_texts(125, 11, 11);
	endtask

	// ------------------------------------------------------------------
	// Output side: check each accepted byte, then pick the next ready.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (emitted_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result out_byte=%02h last_of_run=%0b",
					out_byte, last_of_run));
			end else begin
				oldest = emitted_q.pop_front();
				if (out_byte !== oldest.data || last_of_run !== oldest.last)
					report_mismatch($sformatf(
						"out_byte exp %02h got %02h, last_of_run exp %0b got %0b",
						oldest.data, out_byte, oldest.last, last_of_run));
			end
		end
		out_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// Hang guard: count cycles in which no request moves on either side.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
			else quiet++;
		end
		$display("tb_sql_create_table_extractor: FAIL");
		$finish;
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_match();
		test_no_idling();
		test_sender_gaps();
		test_receiver_stalls();
		test_both_idle();
		if (mismatches == 0 && emitted_q.size() == 0) begin
			$display("tb_sql_create_table_extractor: PASS");
		end else begin
			$display("tb_sql_create_table_extractor: FAIL");
		end
		$finish;
	end

endmodule
